FILE: hdl/fspp_pkg.sv
package fspp_pkg;

    localparam int unsigned CFG_DIM_W    = 13;
    localparam int unsigned CFG_BPP_W    = 3;
    localparam int unsigned CFG_LAYOUT_W = 27;
    localparam int unsigned CFG_DATA_W   = 27;
    localparam int unsigned CFG_IDX_W    = 3;

    localparam int unsigned COORD_W  = 12;
    localparam int unsigned OFFSET_W = 26;
    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned S_DATA_W = 32;
    localparam int unsigned M_DATA_W = 88;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT     = 3'd5;

    localparam logic [CFG_DIM_W-1:0]    RST_SRC_WIDTH  = 13'd640;
    localparam logic [CFG_DIM_W-1:0]    RST_SRC_HEIGHT = 13'd480;
    localparam logic [CFG_DIM_W-1:0]    RST_FB_WIDTH   = 13'd640;
    localparam logic [CFG_DIM_W-1:0]    RST_FB_HEIGHT  = 13'd480;
    localparam logic [CFG_BPP_W-1:0]    RST_BPP        = 3'd4;
    localparam logic [CFG_LAYOUT_W-1:0] RST_LAYOUT     = 27'd67244304;

    typedef struct packed {
        logic take;
        logic wrap;
        logic setup_mul;
        logic div_start;
        logic div_setup;
        logic setup_fin;
        logic blend;
        logic addr;
        logic emit;
        logic store_wanted;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic frame_start;
        logic keep;
        logic div_busy;
        logic out_free;
    } t_stat;

    // floor(v/255), exact for any 16-bit product of two bytes
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    function automatic logic [PIXEL_W-1:0] place_channel(input logic [7:0] v,
                                                         input logic [8:0] grp);
        logic [3:0] size;
        logic [7:0] sh;
        size = grp[8:5];
        if (size == 4'd0 || size > 4'd8) begin
            size = 4'd8;
        end
        sh = v >> (4'd8 - size);
        return {24'd0, sh} << grp[4:0];
    endfunction

    function automatic logic [PIXEL_W-1:0] byte_mask(input logic [CFG_BPP_W-1:0] bpp);
        logic [PIXEL_W-1:0] m;
        case (bpp)
            3'd0, 3'd1: m = 32'h0000_00FF;
            3'd2:       m = 32'h0000_FFFF;
            3'd3:       m = 32'h00FF_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] eff_bpp(input logic [CFG_BPP_W-1:0] bpp);
        logic [2:0] b;
        if (bpp == 3'd0) begin
            b = 3'd1;
        end else if (bpp > 3'd4) begin
            b = 3'd4;
        end else begin
            b = bpp;
        end
        return b;
    endfunction

endpackage

FILE: hdl/fspp_div.sv
module fspp_div #(
    parameter int unsigned NW = 26,
    parameter int unsigned DW = 13
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quotient
);

    localparam int unsigned CW = $clog2(NW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_div;
    logic [DW+1:0] w_try;
    logic [DW+1:0] w_sub;

    assign w_try = {r_rem, r_quo[NW-1]};
    assign w_sub = w_try - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // one quotient bit a cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!w_sub[DW+1]) begin
                r_rem <= w_sub[DW:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_try[DW:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo[DW-1:0];

`ifndef SYNTH
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> ({1'b0, r_div} == '0 || r_rem < {1'b0, r_div}))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: hdl/fspp_ctrl.sv
module fspp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  fspp_pkg::t_stat i_stat,
    output fspp_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRAP, ST_START, ST_SMUL, ST_SDIV, ST_SWAIT, ST_SFIN,
        ST_CHECK, ST_BLEND, ST_ADDR, ST_EMIT, ST_TDIV, ST_TWAIT, ST_TSTORE, ST_ADV
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.take = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = ST_START;
            end
            ST_START: begin
                n_state = i_stat.frame_start ? ST_SMUL : ST_CHECK;
            end
            ST_SMUL: begin
                o_cmd.setup_mul = 1'b1;
                n_state         = ST_SDIV;
            end
            ST_SDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_setup = 1'b1;
                n_state         = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_SFIN;
                end
            end
            ST_SFIN: begin
                o_cmd.setup_fin = 1'b1;
                n_state         = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_stat.keep ? ST_BLEND : ST_ADV;
            end
            ST_BLEND: begin
                o_cmd.blend = 1'b1;
                n_state     = ST_ADDR;
            end
            ST_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_TDIV;
                end
            end
            ST_TDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_TWAIT;
            end
            ST_TWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_TSTORE;
                end
            end
            ST_TSTORE: begin
                o_cmd.store_wanted = 1'b1;
                n_state            = ST_ADV;
            end
            ST_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

`ifndef SYNTH
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy)
        else $error("divider started while busy");
`endif

endmodule

FILE: hdl/fspp_dp.sv
module fspp_dp #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [fspp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fspp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [fspp_pkg::S_DATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [fspp_pkg::M_DATA_W-1:0]   o_m_tdata,
    output logic                            o_m_tlast,
    input  fspp_pkg::t_cmd                  i_cmd,
    output fspp_pkg::t_stat                 o_stat
);

    localparam int unsigned DW = $clog2(MAX_DIM) + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned OW = PW + 3;

    function automatic logic [DW-1:0] eff_dim(input logic [fspp_pkg::CFG_DIM_W-1:0] v);
        logic [DW-1:0] e;
        if (v == '0) begin
            e = DW'(1);
        end else if (32'(v) > MAX_DIM) begin
            e = DW'(MAX_DIM);
        end else begin
            e = DW'(v);
        end
        return e;
    endfunction

    logic [fspp_pkg::CFG_DIM_W-1:0]    r_src_w, r_src_h, r_fb_w, r_fb_h;
    logic [fspp_pkg::CFG_BPP_W-1:0]    r_bpp;
    logic [fspp_pkg::CFG_LAYOUT_W-1:0] r_layout;

    logic [DW-1:0] w_sw, w_sh, w_fw, w_fh;
    logic [DW-2:0] r_scol, r_srow, r_lm, r_tm;
    logic [DW-1:0] r_fit_w, r_fit_h, r_dcol, r_drow, r_wcol, r_wrow;
    logic [7:0]    r_red, r_grn, r_blu, r_alp, r_rb, r_gb, r_bb;
    logic [PW-1:0] r_p, r_q, r_stepnum, r_lin;
    logic          r_need_fit, r_ple, r_rowstep, r_last;
    logic [DW-1:0] r_x, r_y;

    logic          r_ovalid;
    logic [fspp_pkg::M_DATA_W-1:0] r_odata;
    logic          r_olast;

    logic [DW-1:0] w_quo, w_dw, w_dh, w_quo1, w_dcol1, w_drow1;
    logic          w_div_busy, w_ple;
    logic [PW-1:0] w_dividend;
    logic [DW-1:0] w_divisor;
    logic [OW-1:0] w_offw;
    logic [fspp_pkg::PIXEL_W-1:0] w_pix;
    logic [DW-1:0] w_scol1, w_srow1;

    assign w_sw = eff_dim(r_src_w);
    assign w_sh = eff_dim(r_src_h);
    assign w_fw = eff_dim(r_fb_w);
    assign w_fh = eff_dim(r_fb_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= fspp_pkg::RST_SRC_WIDTH;
            r_src_h  <= fspp_pkg::RST_SRC_HEIGHT;
            r_fb_w   <= fspp_pkg::RST_FB_WIDTH;
            r_fb_h   <= fspp_pkg::RST_FB_HEIGHT;
            r_bpp    <= fspp_pkg::RST_BPP;
            r_layout <= fspp_pkg::RST_LAYOUT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fspp_pkg::CFG_SRC_WIDTH:  r_src_w  <= i_cfg_data[fspp_pkg::CFG_DIM_W-1:0];
                fspp_pkg::CFG_SRC_HEIGHT: r_src_h  <= i_cfg_data[fspp_pkg::CFG_DIM_W-1:0];
                fspp_pkg::CFG_FB_WIDTH:   r_fb_w   <= i_cfg_data[fspp_pkg::CFG_DIM_W-1:0];
                fspp_pkg::CFG_FB_HEIGHT:  r_fb_h   <= i_cfg_data[fspp_pkg::CFG_DIM_W-1:0];
                fspp_pkg::CFG_BPP:        r_bpp    <= i_cfg_data[fspp_pkg::CFG_BPP_W-1:0];
                fspp_pkg::CFG_LAYOUT:     r_layout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_ple      = (r_p <= r_q);
    assign w_dividend = i_cmd.div_setup ? (w_ple ? r_p : r_q) : r_stepnum;
    assign w_divisor  = i_cmd.div_setup ? (w_ple ? w_sw : w_sh)
                                        : (r_rowstep ? r_fit_h : r_fit_w);

    fspp_div #(.NW(PW), .DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // clamp the shrunk side to at least one pixel
    assign w_quo1 = (w_quo == '0) ? DW'(1) : w_quo;
    assign w_dw   = !r_need_fit ? w_sw : (r_ple ? w_fw : w_quo1);
    assign w_dh   = !r_need_fit ? w_sh : (r_ple ? w_quo1 : w_fh);

    assign w_dcol1 = r_dcol + 1'b1;
    assign w_drow1 = r_drow + 1'b1;
    assign w_scol1 = {1'b0, r_scol} + 1'b1;
    assign w_srow1 = {1'b0, r_srow} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol  <= '0;
            r_srow  <= '0;
            r_fit_w <= '0;
            r_fit_h <= '0;
            r_lm    <= '0;
            r_tm    <= '0;
            r_dcol  <= '0;
            r_drow  <= '0;
            r_wcol  <= '0;
            r_wrow  <= '0;
        end else begin
            if (i_cmd.wrap) begin
                if ({1'b0, r_scol} >= w_sw) r_scol <= '0;
                if ({1'b0, r_srow} >= w_sh) r_srow <= '0;
            end
            if (i_cmd.setup_fin) begin
                r_fit_w <= w_dw;
                r_fit_h <= w_dh;
                r_lm    <= (DW-1)'((w_fw - w_dw) >> 1);
                r_tm    <= (DW-1)'((w_fh - w_dh) >> 1);
                r_dcol  <= '0;
                r_drow  <= '0;
                r_wcol  <= '0;
                r_wrow  <= '0;
            end
            if (i_cmd.emit) begin
                if (w_dcol1 >= r_fit_w) begin
                    r_dcol <= '0;
                    r_wcol <= '0;
                    r_drow <= w_drow1;
                end else begin
                    r_dcol <= w_dcol1;
                end
            end
            if (i_cmd.store_wanted) begin
                if (r_rowstep) r_wrow <= w_quo;
                else           r_wcol <= w_quo;
            end
            if (i_cmd.advance) begin
                if (w_scol1 >= w_sw) begin
                    r_scol <= '0;
                    r_srow <= (w_srow1 >= w_sh) ? '0 : w_srow1[DW-2:0];
                end else begin
                    r_scol <= w_scol1[DW-2:0];
                end
            end
        end
    end

    assign w_pix = (fspp_pkg::place_channel(r_rb, r_layout[8:0])
                  | fspp_pkg::place_channel(r_gb, r_layout[17:9])
                  | fspp_pkg::place_channel(r_bb, r_layout[26:18]))
                  & fspp_pkg::byte_mask(r_bpp);
    assign w_offw = OW'(r_lin) * OW'(fspp_pkg::eff_bpp(r_bpp));

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_red <= i_s_tdata[7:0];
            r_grn <= i_s_tdata[15:8];
            r_blu <= i_s_tdata[23:16];
            r_alp <= i_s_tdata[31:24];
        end
        if (i_cmd.setup_mul) begin
            r_p        <= {{DW{1'b0}}, w_fw} * {{DW{1'b0}}, w_sh};
            r_q        <= {{DW{1'b0}}, w_fh} * {{DW{1'b0}}, w_sw};
            r_need_fit <= (w_sw > w_fw) || (w_sh > w_fh);
        end
        if (i_cmd.div_start && i_cmd.div_setup) begin
            r_ple <= w_ple;
        end
        if (i_cmd.blend) begin
            r_rb   <= fspp_pkg::div255({8'd0, r_red} * {8'd0, r_alp});
            r_gb   <= fspp_pkg::div255({8'd0, r_grn} * {8'd0, r_alp});
            r_bb   <= fspp_pkg::div255({8'd0, r_blu} * {8'd0, r_alp});
            r_x    <= {1'b0, r_lm} + r_dcol;
            r_y    <= {1'b0, r_tm} + r_drow;
            r_last <= (w_dcol1 == r_fit_w) && (w_drow1 == r_fit_h);
        end
        if (i_cmd.addr) begin
            r_lin <= {{DW{1'b0}}, r_y} * {{DW{1'b0}}, w_fw} + PW'(r_x);
        end
        if (i_cmd.emit) begin
            r_rowstep <= (w_dcol1 >= r_fit_w);
            if (w_dcol1 >= r_fit_w) begin
                r_stepnum <= {{DW{1'b0}}, w_drow1} * {{DW{1'b0}}, w_sh};
            end else begin
                r_stepnum <= {{DW{1'b0}}, w_dcol1} * {{DW{1'b0}}, w_sw};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odata <= {6'd0, w_pix, fspp_pkg::OFFSET_W'(w_offw),
                        fspp_pkg::COORD_W'(r_y), fspp_pkg::COORD_W'(r_x)};
            r_olast <= r_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    assign o_stat.frame_start = (r_scol == '0) && (r_srow == '0);
    assign o_stat.keep        = (r_fit_w != '0) && (r_fit_h != '0)
                              && (r_drow < r_fit_h) && (r_dcol < r_fit_w)
                              && ({1'b0, r_scol} == r_wcol) && ({1'b0, r_srow} == r_wrow);
    assign o_stat.div_busy    = w_div_busy;
    assign o_stat.out_free    = !r_ovalid || i_m_tready;

`ifndef SYNTH
    a_emit_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_dcol < r_fit_w && r_drow < r_fit_h))
        else $error("pixel emitted outside the fitted frame");
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_ovalid || i_m_tready))
        else $error("output register overwritten");
`endif

endmodule

FILE: hdl/fit_scale_blend_pack_pixels_core.sv
// Sequence: a pixel passes wrap, start and keep check; a kept pixel goes on through blend,
// address and emit (held in emit while the output slot is full) and is registered on the output.
// After emit, a kept pixel waits for the bit-serial divider to find the next wanted source column
// or row; a dropped pixel goes straight to advance. The first pixel of a frame adds fitting setup.
// One pixel at a time; the next is taken when the previous one is finished.
// Reset: i_rst_n, synchronous active low; registers load their defaults, counters clear.
module fit_scale_blend_pack_pixels_core #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [26:0] i_cfg_data,
    // source pixel beats
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    // destination pixel beats
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // dest_x[11:0], dest_y[23:12], byte_offset[49:24],
                                     // pixel_value[81:50], zero[87:82]
    output logic        o_m_tlast    // last_pixel
);

    fspp_pkg::t_cmd  w_cmd;
    fspp_pkg::t_stat w_stat;

    // registers are plain flops, so every write is taken at once
    assign o_cfg_ready = 1'b1;

    // sequencer: steps each beat through wrap, setup at a frame start, keep test, then blend, address, emit if kept
    fspp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: config, counters, fitting divider, blend and packing
    fspp_dp #(.MAX_DIM(MAX_DIM)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

FILE: test/fit_scale_blend_pack_pixels_core_tb.sv
module fit_scale_blend_pack_pixels_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DIM_LIMIT = 4096;
    // covers fitting setup, a kept pixel and the drop path with room to spare
    localparam int unsigned SETTLE_CYCLES = 120;

    typedef struct {
        logic [fspp_pkg::COORD_W-1:0]  x;
        logic [fspp_pkg::COORD_W-1:0]  y;
        logic [fspp_pkg::OFFSET_W-1:0] offset;
        logic [fspp_pkg::PIXEL_W-1:0]  value;
        logic                          last;
    } t_dest_pixel;

    // Predicts the written framebuffer pixels and checks them in order.
    class pixel_scoreboard;
        int unsigned src_w, src_h, fb_w, fb_h, bpp_reg, layout;
        int unsigned src_col, src_row, fit_w, fit_h, left_m, top_m;
        int unsigned out_col, out_row, want_col, want_row;
        t_dest_pixel pending[$];
        int unsigned errors;

        function new();
            src_w = 32'(fspp_pkg::RST_SRC_WIDTH);
            src_h = 32'(fspp_pkg::RST_SRC_HEIGHT);
            fb_w = 32'(fspp_pkg::RST_FB_WIDTH);
            fb_h = 32'(fspp_pkg::RST_FB_HEIGHT);
            bpp_reg = 32'(fspp_pkg::RST_BPP);
            layout = 32'(fspp_pkg::RST_LAYOUT);
            src_col = 0; src_row = 0; fit_w = 0; fit_h = 0; left_m = 0; top_m = 0;
            out_col = 0; out_row = 0; want_col = 0; want_row = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [fspp_pkg::CFG_IDX_W-1:0] idx,
                                logic [fspp_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                fspp_pkg::CFG_SRC_WIDTH:  src_w = 32'(d[fspp_pkg::CFG_DIM_W-1:0]);
                fspp_pkg::CFG_SRC_HEIGHT: src_h = 32'(d[fspp_pkg::CFG_DIM_W-1:0]);
                fspp_pkg::CFG_FB_WIDTH:   fb_w = 32'(d[fspp_pkg::CFG_DIM_W-1:0]);
                fspp_pkg::CFG_FB_HEIGHT:  fb_h = 32'(d[fspp_pkg::CFG_DIM_W-1:0]);
                fspp_pkg::CFG_BPP:        bpp_reg = 32'(d[fspp_pkg::CFG_BPP_W-1:0]);
                fspp_pkg::CFG_LAYOUT:     layout = 32'(d[fspp_pkg::CFG_LAYOUT_W-1:0]);
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            if (v == 0) return 1;
            if (v > DIM_LIMIT) return DIM_LIMIT;
            return v;
        endfunction

        // shift a blended channel down to its size and up to its position
        function longint unsigned channel_bits(int unsigned v, int unsigned grp);
            int unsigned size;
            size = (grp >> 5) & 15;
            if (size == 0 || size > 8) size = 8;
            return longint'(v >> (8 - size)) << (grp & 31);
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
            int unsigned sw, sh, fw, fh, bpp, x, y, rb, gb, bb;
            longint unsigned px;
            t_dest_pixel e;
            sw = clamp_dim(src_w);
            sh = clamp_dim(src_h);
            fw = clamp_dim(fb_w);
            fh = clamp_dim(fb_h);
            if (src_col >= sw) src_col = 0;
            if (src_row >= sh) src_row = 0;

            // fit on the first pixel of a frame: shrink only, keep aspect
            if (src_col == 0 && src_row == 0) begin
                fit_w = sw;
                fit_h = sh;
                if (sw > fw || sh > fh) begin
                    if (longint'(fw) * sh <= longint'(fh) * sw) begin
                        fit_w = fw;
                        fit_h = 32'((longint'(sh) * fw) / sw);
                    end else begin
                        fit_w = 32'((longint'(sw) * fh) / sh);
                        fit_h = fh;
                    end
                    if (fit_w < 1) fit_w = 1;
                    if (fit_h < 1) fit_h = 1;
                end
                left_m = (fw - fit_w) / 2;
                top_m = (fh - fit_h) / 2;
                out_col = 0; out_row = 0; want_col = 0; want_row = 0;
            end

            if (fit_w != 0 && fit_h != 0 && out_row < fit_h && out_col < fit_w &&
                src_col == want_col && src_row == want_row) begin
                bpp = (bpp_reg == 0) ? 1 : (bpp_reg > 4) ? 4 : bpp_reg;
                x = left_m + out_col;
                y = top_m + out_row;
                rb = (32'(r) * 32'(a)) / 255;
                gb = (32'(g) * 32'(a)) / 255;
                bb = (32'(b) * 32'(a)) / 255;
                px = channel_bits(rb, layout & 'h1FF) | channel_bits(gb, (layout >> 9) & 'h1FF)
                   | channel_bits(bb, (layout >> 18) & 'h1FF);
                px &= ((64'd1 << (8 * bpp)) - 1) & 64'hFFFF_FFFF;
                e.x = x[fspp_pkg::COORD_W-1:0];
                e.y = y[fspp_pkg::COORD_W-1:0];
                e.offset = fspp_pkg::OFFSET_W'((longint'(y) * fw + x) * bpp);
                e.value = px[fspp_pkg::PIXEL_W-1:0];
                e.last = (out_col + 1 == fit_w) && (out_row + 1 == fit_h);
                pending.push_back(e);

                out_col++;
                if (out_col >= fit_w) begin
                    out_col = 0;
                    want_col = 0;
                    out_row++;
                    want_row = 32'((longint'(out_row) * sh) / fit_h);
                end else begin
                    want_col = 32'((longint'(out_col) * sw) / fit_w);
                end
            end

            src_col++;
            if (src_col >= sw) begin
                src_col = 0;
                src_row++;
                if (src_row >= sh) src_row = 0;
            end
        endfunction

        function void check_result(logic [fspp_pkg::M_DATA_W-1:0] d, logic last);
            t_dest_pixel e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel beat: expected none, actual data %h last %b",
                         $realtime, d, last);
                return;
            end
            e = pending.pop_front();
            if (d[11:0] !== e.x || d[23:12] !== e.y || d[49:24] !== e.offset ||
                d[81:50] !== e.value || last !== e.last) begin
                errors++;
                $display("%0t: pixel mismatch: expected x %0d y %0d off %0d val %h last %b",
                         $realtime, e.x, e.y, e.offset, e.value, e.last);
                $display("%0t:                 actual   x %0d y %0d off %0d val %h last %b",
                         $realtime, d[11:0], d[23:12], d[49:24], d[81:50], last);
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [fspp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [fspp_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [fspp_pkg::S_DATA_W-1:0]   i_s_tdata;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [fspp_pkg::M_DATA_W-1:0]   o_m_tdata;
    logic                            o_m_tlast;

    pixel_scoreboard board = new();
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    fit_scale_blend_pack_pixels_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Stall the output side at the current rate; zero rate keeps ready high.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every accepted output beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_result(o_m_tdata, o_m_tlast);
        end
    end

    // Write one register; the predictor takes it on the handshake.
    task automatic write_reg(logic [fspp_pkg::CFG_IDX_W-1:0] idx,
                             logic [fspp_pkg::CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(int unsigned sw, int unsigned sh, int unsigned fw,
                             int unsigned fh, int unsigned bpp, int unsigned lay);
        write_reg(fspp_pkg::CFG_SRC_WIDTH, fspp_pkg::CFG_DATA_W'(sw));
        write_reg(fspp_pkg::CFG_SRC_HEIGHT, fspp_pkg::CFG_DATA_W'(sh));
        write_reg(fspp_pkg::CFG_FB_WIDTH, fspp_pkg::CFG_DATA_W'(fw));
        write_reg(fspp_pkg::CFG_FB_HEIGHT, fspp_pkg::CFG_DATA_W'(fh));
        write_reg(fspp_pkg::CFG_BPP, fspp_pkg::CFG_DATA_W'(bpp));
        write_reg(fspp_pkg::CFG_LAYOUT, fspp_pkg::CFG_DATA_W'(lay));
    endtask

    // Offer one source pixel beat, sometimes with valid dropped first; keep valid high after.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {a, b, g, r};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_pixel(r, g, b, a);
    endtask

    task automatic send_random_pixel();
        logic [7:0] a;
        case ($urandom_range(0, 3))
            0: a = 8'hFF;
            1: a = 8'h00;
            default: a = 8'($urandom_range(0, 255));
        endcase
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), a);
    endtask

    // Hold the source until every predicted pixel has left the block.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // Drain, then let a dropped pixel or a fitting pass finish before reconfiguring.
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_dim(int unsigned hi);
        case ($urandom_range(0, 15))
            0: return 0;
            1: return 8191;
            2: return DIM_LIMIT;
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    initial begin
        int unsigned sw, sh;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        send_idle_pct = 10;
        recv_idle_pct = 59;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Shrink 4x3 onto 2x2 with zero bytes per pixel; walk channel and alpha extremes.
        write_all(4, 3, 2, 2, 0, {4'd5, 5'd11, 4'd6, 5'd5, 4'd5, 5'd0});
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
        send_pixel(8'h80, 8'h7F, 8'h01, 8'hFE);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01);
        send_pixel(8'hAA, 8'h55, 8'hAA, 8'h80);
        send_pixel(8'h55, 8'hAA, 8'h55, 8'h7F);
        send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'h00, 8'hFF, 8'hFF);
        send_pixel(8'h01, 8'h02, 8'h04, 8'h40);
        send_pixel(8'hFE, 8'hFD, 8'hFB, 8'hBF);
        settle();

        // One-pixel source centered on an oversized framebuffer; sizes 0 and 15 act as 8,
        // a channel at bit 31 loses its upper bits, bytes per pixel above 4 acts as 4.
        write_all(1, 1, 8191, 8191, 7, {4'd15, 5'd31, 4'd0, 5'd28, 4'd8, 5'd0});
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        send_pixel(8'hED, 8'hCB, 8'hA9, 8'hFF);
        settle();

        // Zero-width, maximum-height source: fitted width floors to zero and rises to 1.
        write_all(0, 8191, 4, 2, 3, 27'h7FF_FFFF);
        repeat (12) send_random_pixel();
        settle();

        // Leave a frame half done, then shrink the source so the counters wrap.
        write_all(6, 5, 3, 3, 2, $urandom());
        repeat (20) send_random_pixel();
        settle();
        write_all(2, 2, 8, 8, 1, $urandom());
        repeat (6) send_random_pixel();
        settle();

        for (int phase = 0; phase < 9; phase++) begin
            if (phase < 3) begin
                send_idle_pct = 10;
                recv_idle_pct = 59;
            end else if (phase < 6) begin
                send_idle_pct = 59;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Keep the source small so frames stay short; the framebuffer may be anything.
            sw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 8);
            sh = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 8);
            write_all(sw, sh, pick_dim(10), pick_dim(10), $urandom_range(0, 7), $urandom());
            for (int n = 0; n < 135; n++) begin
                if ($urandom_range(0, 63) == 0) drain();
                send_random_pixel();
            end
            settle();
        end

        i_s_tvalid <= 1'b0;
        settle();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("fit_scale_blend_pack_pixels_core verification clean");
        end else begin
            $display("fit_scale_blend_pack_pixels_core verification failed");
        end
        $finish;
    end

    // Bound the run well beyond the slowest legal schedule.
    initial begin
        #20ms;
        $display("fit_scale_blend_pack_pixels_core verification failed");
        $finish;
    end

endmodule
